/* design/cdll_pkg.sv */
package cdll_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  typedef logic [2:0] req_type_t;
  typedef logic [1:0] status_t;

  // Request kinds.
  localparam req_type_t REQ_INS_FRONT = 3'd0;
  localparam req_type_t REQ_INS_BACK  = 3'd1;
  localparam req_type_t REQ_DEL_FRONT = 3'd2;
  localparam req_type_t REQ_DEL_BACK  = 3'd3;
  localparam req_type_t REQ_INS_AT    = 3'd4;
  localparam req_type_t REQ_DEL_AT    = 3'd5;

  // Result status codes.
  localparam status_t STS_OK     = 2'd0;
  localparam status_t STS_BADPOS = 2'd1;
  localparam status_t STS_EMPTY  = 2'd2;
  localparam status_t STS_FULL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic walk_start;
    logic walk_step;
    logic ins_rd;
    logic ins_cap;
    logic ins_wr1;
    logic ins_wr2;
    logic del_rd;
    logic del_cap;
    logic del_wr;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chk_err;
    logic op_ins;
    logic steps_zero;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

/* design/cdll_ctrl.sv */
module cdll_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdll_pkg::sts_t sts,
  output cdll_pkg::cmd_t cmd
);
  import cdll_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WSTART = 4'd1;
  localparam logic [3:0] ST_WALK   = 4'd2;
  localparam logic [3:0] ST_IRD    = 4'd3;
  localparam logic [3:0] ST_ICAP   = 4'd4;
  localparam logic [3:0] ST_IWR1   = 4'd5;
  localparam logic [3:0] ST_IWR2   = 4'd6;
  localparam logic [3:0] ST_DRD    = 4'd7;
  localparam logic [3:0] ST_DCAP   = 4'd8;
  localparam logic [3:0] ST_DWR    = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.chk_err ? ST_FIN : ST_WSTART;
        end
      end
      ST_WSTART: begin
        if (sts.steps_zero) begin
          state_nxt = sts.op_ins ? ST_IRD : ST_DRD;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = sts.op_ins ? ST_IRD : ST_DRD;
        end
      end
      ST_IRD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = ST_ICAP;
      end
      ST_ICAP: begin
        cmd.ins_cap = 1'b1;
        state_nxt   = ST_IWR1;
      end
      ST_IWR1: begin
        cmd.ins_wr1 = 1'b1;
        state_nxt   = ST_IWR2;
      end
      ST_IWR2: begin
        cmd.ins_wr2 = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_DRD: begin
        cmd.del_rd = 1'b1;
        state_nxt  = ST_DCAP;
      end
      ST_DCAP: begin
        cmd.del_cap = 1'b1;
        state_nxt   = ST_DWR;
      end
      ST_DWR: begin
        cmd.del_wr = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // A rejected request skips all list work and goes straight to the result.
  a_reject_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.chk_err |=> state_r == ST_FIN)
    else $error("rejected request did not go to the result state");
`endif

endmodule

/* design/cdll_dp.sv */
module cdll_dp #(
  parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cdll_pkg::cmd_t                     cmd,
  output cdll_pkg::sts_t                     sts,
  input  cdll_pkg::req_type_t                in_req_type,
  input  logic signed [DATA_WIDTH-1:0]       in_value,
  input  logic [$clog2(CAPACITY+1)-1:0]      in_position,
  input  logic                               out_ready,
  output logic                               out_valid,
  output cdll_pkg::status_t                  out_status,
  output logic [$clog2(CAPACITY+1)-1:0]      out_element_count,
  output logic signed [DATA_WIDTH-1:0]       out_first_value,
  output logic signed [DATA_WIDTH-1:0]       out_last_value
);
  import cdll_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Node storage.
  logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
  logic [AW-1:0]         nxt_mem  [CAPACITY];
  logic [AW-1:0]         prv_mem  [CAPACITY];
  logic [AW-1:0]         free_mem [CAPACITY];

  logic [DATA_WIDTH-1:0] val_q;
  logic [AW-1:0]         nxt_q;
  logic [AW-1:0]         prv_q;
  logic [AW-1:0]         free_q;

  // List state.
  logic [AW-1:0]         head_r;
  logic [AW-1:0]         tail_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         hw_r;
  logic [DATA_WIDTH-1:0] head_val_r;
  logic [DATA_WIDTH-1:0] tail_val_r;

  // Captured request.
  status_t               st_r;
  logic                  ins_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  at_head_r;
  logic                  at_tail_r;
  logic                  cnt0_r;
  logic                  fresh_r;
  logic [CW-1:0]         rem_r;
  logic [AW-1:0]         cur_r;
  logic [AW-1:0]         a_r;
  logic [AW-1:0]         b_r;
  logic [AW-1:0]         n_r;

  // Result register.
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [CW-1:0]         out_count_r;
  logic [DATA_WIDTH-1:0] out_first_r;
  logic [DATA_WIDTH-1:0] out_last_r;

  // Request check.
  logic          full_c;
  logic          cnt0_c;
  logic [CW:0]   cnt_x;
  logic [CW:0]   cnt_p1;
  logic [CW:0]   pos_x;
  logic [CW:0]   p_sel;
  logic [CW:0]   steps_c;
  status_t       chk_st;
  logic          chk_ins;
  logic          at_head_c;
  logic          at_tail_c;

  logic [CW-1:0] pop_full;
  logic [CW-1:0] push_full;
  logic [AW-1:0] pop_idx;
  logic [AW-1:0] push_idx;
  logic [AW-1:0] new_slot;

  always_comb begin
    cnt_x   = {1'b0, count_r};
    cnt_p1  = cnt_x + (CW+1)'(1);
    pos_x   = {1'b0, in_position};
    full_c  = (count_r == CW'(CAPACITY));
    cnt0_c  = (count_r == '0);
    chk_st  = STS_OK;
    chk_ins = 1'b0;
    p_sel   = (CW+1)'(1);
    unique case (in_req_type)
      REQ_INS_FRONT: begin
        chk_ins = 1'b1;
        if (full_c) chk_st = STS_FULL;
      end
      REQ_INS_BACK: begin
        chk_ins = 1'b1;
        p_sel   = cnt_p1;
        if (full_c) chk_st = STS_FULL;
      end
      REQ_DEL_FRONT: begin
        if (cnt0_c) chk_st = STS_EMPTY;
      end
      REQ_DEL_BACK: begin
        p_sel = cnt_x;
        if (cnt0_c) chk_st = STS_EMPTY;
      end
      REQ_INS_AT: begin
        chk_ins = 1'b1;
        p_sel   = pos_x;
        if (pos_x == '0 || pos_x > cnt_p1) begin
          chk_st = STS_BADPOS;
        end else if (full_c) begin
          chk_st = STS_FULL;
        end
      end
      REQ_DEL_AT: begin
        p_sel = pos_x;
        if (cnt0_c) begin
          chk_st = STS_EMPTY;
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          chk_st = STS_BADPOS;
        end
      end
      default: begin
        chk_st = STS_BADPOS;
      end
    endcase
    at_head_c = (p_sel == (CW+1)'(1));
    at_tail_c = chk_ins ? (p_sel == cnt_p1) : (p_sel == cnt_x);
    // The walk starts at the tail: an insert needs the node before the new
    // one, a delete needs the node itself.
    if (at_tail_c) begin
      steps_c = '0;
    end else if (chk_ins) begin
      steps_c = p_sel - (CW+1)'(1);
    end else begin
      steps_c = p_sel;
    end
  end

  assign pop_full  = CW'(CAPACITY - 1) - count_r;
  assign push_full = CW'(CAPACITY) - count_r;
  assign pop_idx   = pop_full[AW-1:0];
  assign push_idx  = push_full[AW-1:0];
  // Stack entries past the high-water mark were never written; a fresh slot is its own stack index.
  assign new_slot  = fresh_r ? pop_idx : free_q;

  // Memory port selection.
  logic          nxt_we;
  logic [AW-1:0] nxt_waddr;
  logic [AW-1:0] nxt_wdata;
  logic          nxt_re;
  logic [AW-1:0] nxt_raddr;
  logic          prv_we;
  logic [AW-1:0] prv_waddr;
  logic [AW-1:0] prv_wdata;
  logic [AW-1:0] val_raddr;

  always_comb begin
    nxt_we    = cmd.ins_wr1 | cmd.ins_wr2 | cmd.del_wr;
    nxt_waddr = cmd.ins_wr2 ? n_r : a_r;
    nxt_wdata = cmd.ins_wr1 ? n_r : b_r;
    nxt_re    = cmd.walk_start | cmd.walk_step | cmd.ins_rd | cmd.del_rd;
    nxt_raddr = cmd.walk_step ? nxt_q : cur_r;
    prv_we    = cmd.ins_wr1 | cmd.ins_wr2 | cmd.del_wr;
    prv_waddr = cmd.ins_wr2 ? n_r : b_r;
    prv_wdata = cmd.ins_wr1 ? n_r : a_r;
    val_raddr = at_head_r ? nxt_q : prv_q;
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    if (nxt_re) nxt_q <= nxt_mem[nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
    if (cmd.del_rd) prv_q <= prv_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr1) val_mem[n_r] <= val_r;
    if (cmd.del_cap) val_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.del_wr) free_mem[push_idx] <= cur_r;
    if (cmd.ins_rd) free_q <= free_mem[pop_idx];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_wr2) begin
        count_r <= count_r + CW'(1);
        if (fresh_r) hw_r <= hw_r + CW'(1);
        if (at_head_r) head_r <= n_r;
        if (at_tail_r) tail_r <= n_r;
      end
      if (cmd.del_wr) begin
        count_r <= count_r - CW'(1);
        if (at_head_r) head_r <= b_r;
        if (at_tail_r) tail_r <= a_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_r      <= chk_st;
      ins_r     <= chk_ins;
      val_r     <= in_value;
      at_head_r <= at_head_c;
      at_tail_r <= at_tail_c;
      cnt0_r    <= cnt0_c;
      fresh_r   <= (count_r == hw_r);
      rem_r     <= steps_c[CW-1:0];
      cur_r     <= tail_r;
    end
    if (cmd.walk_step) begin
      if (rem_r == CW'(1)) begin
        cur_r <= nxt_q;
      end else begin
        rem_r <= rem_r - CW'(1);
      end
    end
    if (cmd.ins_cap) begin
      n_r <= new_slot;
      a_r <= cnt0_r ? new_slot : cur_r;
      b_r <= cnt0_r ? new_slot : nxt_q;
    end
    if (cmd.del_cap) begin
      a_r <= prv_q;
      b_r <= nxt_q;
    end
    if (cmd.ins_wr2) begin
      if (at_head_r) head_val_r <= val_r;
      if (at_tail_r) tail_val_r <= val_r;
    end
    if (cmd.del_wr) begin
      if (at_head_r) head_val_r <= val_q;
      if (at_tail_r) tail_val_r <= val_q;
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_count_r  <= count_r;
      out_first_r  <= (count_r == '0) ? '0 : head_val_r;
      out_last_r   <= (count_r == '0) ? '0 : tail_val_r;
    end
  end

  always_comb begin
    sts.chk_err    = (chk_st != STS_OK);
    sts.op_ins     = ins_r;
    sts.steps_zero = (rem_r == '0);
    sts.walk_last  = (rem_r == CW'(1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;
  assign out_first_value   = out_first_r;
  assign out_last_value    = out_last_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_hw: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hw_r)
    else $error("element count above slot high-water mark");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins_wr2 || cmd.del_wr) |=> $stable(count_r))
    else $error("element count changed outside a list update");
`endif

endmodule

/* design/circular_doubly_linked_list.sv */
// Bounded circular doubly linked list of signed values with a request/result
// valid-ready interface. Each request inserts or deletes at the front, the
// back, or a 1-based position, and yields exactly one result with a status,
// the element count and the head and tail values (zero when empty). Requests
// are processed one at a time. A rejected request (bad position, empty or
// full) goes straight to the result; an accepted one walks s link steps when
// a walk is needed, then reads, captures and writes the links before its
// result is loaded into the output register. s is position-1 for an insert
// and position for a delete, and it is zero whenever the position is the
// tail. Inserts at the front or the back never walk; a delete at the front
// walks one step, from the tail to the head, unless the list holds a single
// element. The walk follows the next links from the tail through the link
// memory's single read port, one node per clock. The next request is taken
// at the edge after the result has been moved into the output register; a
// result that is not taken only holds off the following result.
module circular_doubly_linked_list #(
  parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cdll_pkg::req_type_t           in_req_type,
  input  logic signed [DATA_WIDTH-1:0]  in_value,
  input  logic [$clog2(CAPACITY+1)-1:0] in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cdll_pkg::status_t             out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_element_count,
  output logic signed [DATA_WIDTH-1:0]  out_first_value,
  output logic signed [DATA_WIDTH-1:0]  out_last_value
);
  import cdll_pkg::*;

  // Commands and status between the sequencer and the list datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request: check, walk, link update, result.
  cdll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the node, link and free-slot memories, the list
  // pointers and the result register.
  cdll_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_first_value   (out_first_value),
    .out_last_value    (out_last_value)
  );

endmodule

/* dv/circular_doubly_linked_list_tb.sv */
module circular_doubly_linked_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdll_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int DW  = DATA_WIDTH_DEF;
  localparam int PW  = $clog2(CAP + 1);

  // Kinds 6 and 7 are not defined; the block must answer them with a bad
  // position status and leave the list alone.
  localparam req_type_t REQ_UNUSED_6 = 3'd6;
  localparam req_type_t REQ_UNUSED_7 = 3'd7;

  // A positional walk can pass nearly every node of a full list. With long
  // gaps on both sides and roughly 1200 requests the slowest legal run stays
  // well under this bound.
  localparam int LIMIT_CYCLES = 1000000;

  // One result as the block reports it.
  typedef struct {
    status_t               status;
    logic [PW-1:0]         count;
    logic signed [DW-1:0]  first;
    logic signed [DW-1:0]  last;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  req_type_t             in_req_type;
  logic signed [DW-1:0]  in_value;
  logic [PW-1:0]         in_position;
  logic                  out_valid;
  logic                  out_ready;
  status_t               out_status;
  logic [PW-1:0]         out_element_count;
  logic signed [DW-1:0]  out_first_value;
  logic signed [DW-1:0]  out_last_value;

  // The predicted list contents, head first. Ordering is all that matters
  // for the results, so a queue stands in for the slot memory and the links.
  logic signed [DW-1:0]  list_contents[$];

  // Results predicted for accepted requests, oldest first.
  list_result_t          pending_results[$];

  int                    mismatch_count = 0;
  int                    cycle_count = 0;

  // When set, neither side inserts idle cycles, so requests and results
  // go through back to back.
  bit                    no_idle = 1'b0;

  list_result_t          got_result;

  circular_doubly_linked_list #(
    .CAPACITY   (CAP),
    .DATA_WIDTH (DW)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_first_value   (out_first_value),
    .out_last_value    (out_last_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Applies one request to the predicted list and returns the result the
  // block should report. The checks follow the block's priority: for an
  // insert at a position the position is judged before fullness, and for a
  // delete at a position an empty list wins over a bad position.
  function automatic list_result_t apply_request(req_type_t kind,
                                                 logic signed [DW-1:0] val,
                                                 logic [PW-1:0] pos);
    list_result_t r;
    int n;
    int p;
    n = list_contents.size();
    p = int'(pos);
    r.status = STS_OK;
    case (kind)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (n >= CAP) r.status = STS_FULL;
        else if (kind == REQ_INS_FRONT) list_contents.push_front(val);
        else list_contents.push_back(val);
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        if (n == 0) r.status = STS_EMPTY;
        else if (kind == REQ_DEL_FRONT) void'(list_contents.pop_front());
        else void'(list_contents.pop_back());
      end
      REQ_INS_AT: begin
        if (p < 1 || p > n + 1) r.status = STS_BADPOS;
        else if (n >= CAP) r.status = STS_FULL;
        else list_contents.insert(p - 1, val);
      end
      REQ_DEL_AT: begin
        if (n == 0) r.status = STS_EMPTY;
        else if (p < 1 || p > n) r.status = STS_BADPOS;
        else list_contents.delete(p - 1);
      end
      default: r.status = STS_BADPOS;
    endcase
    r.count = PW'(list_contents.size());
    if (list_contents.size() == 0) begin
      r.first = '0;
      r.last  = '0;
    end else begin
      r.first = list_contents[0];
      r.last  = list_contents[$];
    end
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // A position for a positional request where top is the largest legal one.
  // Most picks are legal, some sit on the edges, and the rest span the
  // whole field so that every position bit toggles.
  function automatic logic [PW-1:0] pick_position(int top);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80 && top > 0) return PW'($urandom_range(1, top));
    if (roll < 90) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return PW'(top);
        default: return PW'(top + 1);
      endcase
    end
    return PW'($urandom_range(0, (1 << PW) - 1));
  endfunction

  // Sends one request. Valid stays high from the previous request when no
  // gap is wanted, so a back-to-back request never drops valid for a step.
  // The prediction is made at the accepting edge, in acceptance order.
  task automatic send_request(req_type_t kind, logic signed [DW-1:0] val,
                              logic [PW-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(kind, val, pos));
  endtask

  // Holds off new requests until every predicted result has come back.
  // The final edge keeps the valid drop and any later raise in separate steps.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One random request, inserting with the given percentage. A small share
  // is undefined kinds as noise.
  task automatic send_random(int ins_pct);
    int n;
    req_type_t kind;
    n = list_contents.size();
    if ($urandom_range(0, 99) < 3) begin
      kind = $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
    end else if ($urandom_range(0, 99) < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_INS_FRONT;
        1:       kind = REQ_INS_BACK;
        default: kind = REQ_INS_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       kind = REQ_DEL_FRONT;
        1:       kind = REQ_DEL_BACK;
        default: kind = REQ_DEL_AT;
      endcase
    end
    send_request(kind, $urandom, pick_position(kind == REQ_INS_AT ? n + 1 : n));
  endtask

  // Delete and undefined request kinds against an empty list, positional
  // inserts at out-of-range positions, then a first insert at position one.
  task automatic test_empty_list();
    send_request(REQ_DEL_FRONT, $urandom, '0);
    send_request(REQ_DEL_BACK,  $urandom, '0);
    send_request(REQ_DEL_AT,    $urandom, PW'(1));
    send_request(REQ_DEL_AT,    $urandom, '0);
    send_request(REQ_DEL_AT,    $urandom, '1);
    send_request(REQ_INS_AT,    $urandom, '0);
    send_request(REQ_INS_AT,    $urandom, PW'(2));
    send_request(REQ_UNUSED_6,  $urandom, PW'(1));
    send_request(REQ_UNUSED_7,  $urandom, PW'(1));
    send_request(REQ_INS_AT,    32'sh5a5a_a5a5, PW'(1));
  endtask

  // Extreme values through every insert path, bad positions on a populated
  // list, deletes from the middle, the end and the head, then emptied again.
  task automatic test_value_extremes();
    send_request(REQ_INS_BACK,  32'sh7fff_ffff, '0);
    send_request(REQ_INS_FRONT, 32'sh8000_0000, '1);
    send_request(REQ_INS_AT,    -32'sd1, PW'(2));
    send_request(REQ_INS_AT,    32'sd0, PW'(list_contents.size() + 1));
    send_request(REQ_INS_AT,    $urandom, '1);
    send_request(REQ_UNUSED_7,  $urandom, PW'(2));
    send_request(REQ_DEL_AT,    $urandom, '0);
    send_request(REQ_DEL_AT,    $urandom, PW'(list_contents.size() + 1));
    send_request(REQ_DEL_AT,    $urandom, PW'(3));
    send_request(REQ_DEL_AT,    $urandom, PW'(list_contents.size()));
    send_request(REQ_DEL_AT,    $urandom, PW'(1));
    while (list_contents.size() > 0) begin
      send_request($urandom_range(0, 1) ? REQ_DEL_FRONT : REQ_DEL_BACK, $urandom, '0);
    end
  endtask

  // Fills the list to capacity through all insert paths with deep walks,
  // checks that a full list rejects inserts while a bad position still wins,
  // then drains it back to empty through all delete paths.
  task automatic test_fill_and_drain();
    int n;
    no_idle = 1'b1;
    while (list_contents.size() < CAP) begin
      n = list_contents.size();
      case ($urandom_range(0, 2))
        0:       send_request(REQ_INS_FRONT, $urandom, '0);
        1:       send_request(REQ_INS_BACK, $urandom, '0);
        default: send_request(REQ_INS_AT, $urandom, PW'($urandom_range(1, n + 1)));
      endcase
    end
    no_idle = 1'b0;
    send_request(REQ_INS_FRONT, $urandom, '0);
    send_request(REQ_INS_BACK,  $urandom, '0);
    send_request(REQ_INS_AT,    $urandom, PW'(1));
    send_request(REQ_INS_AT,    $urandom, PW'(CAP + 1));
    send_request(REQ_INS_AT,    $urandom, PW'(CAP + 2));
    send_request(REQ_INS_AT,    $urandom, '0);
    send_request(REQ_DEL_AT,    $urandom, PW'(CAP));
    send_request(REQ_INS_AT,    $urandom, PW'(CAP / 2));
    while (list_contents.size() > 0) begin
      n = list_contents.size();
      case ($urandom_range(0, 2))
        0:       send_request(REQ_DEL_FRONT, $urandom, '0);
        1:       send_request(REQ_DEL_BACK, $urandom, '0);
        default: send_request(REQ_DEL_AT, $urandom, PW'($urandom_range(1, n)));
      endcase
    end
  endtask

  // The bulk of the run: phases that lean toward growth, shrinkage or
  // balance, so the list keeps crossing empty and full. Some phases run
  // without idling, and halfway the sender waits for all results.
  task automatic test_random_mix(int n_items);
    int ins_pct;
    ins_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ((i / 100) % 4)
          0:       ins_pct = 70;
          1:       ins_pct = 30;
          2:       ins_pct = 50;
          default: ins_pct = $urandom_range(20, 80);
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == n_items / 2) wait_drained();
      send_random(ins_pct);
    end
    no_idle = 1'b0;
  endtask

  function automatic void check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endfunction

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request outstanding, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        got_result = pending_results.pop_front();
        check_field("status", got_result.status, out_status);
        check_field("element_count", got_result.count, out_element_count);
        check_field("first_value", got_result.first, out_first_value);
        check_field("last_value", got_result.last, out_last_value);
      end
    end
  end

  // The result side: ready for a random stretch, then a random stall.
  initial begin
    int hold;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = $urandom_range(1, 24);
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_INS_FRONT;
    in_value    <= '0;
    in_position <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_value_extremes();
    test_fill_and_drain();
    wait_drained();
    test_random_mix(1000);

    // Let the last results come back, then give the block time to show any
    // stray result before judging the run.
    wait_drained();
    repeat (CAP + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* circular_doubly_linked_list.f */
design/cdll_pkg.sv
design/cdll_ctrl.sv
design/cdll_dp.sv
design/circular_doubly_linked_list.sv
dv/circular_doubly_linked_list_tb.sv
